FILE: hdl/dssl_pkg.sv
// Package for the dual servo slew limiter: widths, fixed-point constants,
// register indexes and the structs passed between the pipeline modules.
// No dependencies.
`default_nettype none

package dssl_pkg;

   // Position format: unsigned, INT_BITS integer bits, FRAC_BITS fraction bits
   localparam int FRAC_BITS = 10;
   localparam int INT_BITS  = 12;
   localparam int POS_W     = INT_BITS + FRAC_BITS;

   // Field widths
   localparam int US_W      = 12;
   localparam int DUTY_W    = 12;
   localparam int ELAPSED_W = 16;
   localparam int SPEED_W   = 16;
   localparam int PROD_W    = ELAPSED_W + SPEED_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_LEFT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_RIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED        = 3'd4;

   // Register reset values
   localparam logic [US_W-1:0]    MIN_WIDTH_RESET = 12'd1000;
   localparam logic [US_W-1:0]    MAX_WIDTH_RESET = 12'd2000;
   localparam logic [SPEED_W-1:0] SPEED_RESET     = 16'd1000;

   // Travel limits
   localparam int unsigned POS_LOW_US  = 500;
   localparam int unsigned POS_HIGH_US = 2500;
   localparam logic [POS_W-1:0] POS_LOW_FX  = POS_W'(longint'(POS_LOW_US) << FRAC_BITS);
   localparam logic [POS_W-1:0] POS_HIGH_FX = POS_W'(longint'(POS_HIGH_US) << FRAC_BITS);
   localparam logic [POS_W-1:0] POS_FULL    = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_ONE_US  = POS_W'(longint'(1) << FRAC_BITS);

   // Step = floor(elapsed * speed * 2^FRAC_BITS / 1000), saturated.
   // The step saturates exactly when the product reaches 1000 * 2^INT_BITS.
   localparam longint unsigned MS_PER_SEC  = 1000;
   localparam longint unsigned SAT_PRODUCT = MS_PER_SEC << INT_BITS;
   localparam int PSMALL_W = 22;          // holds any product below SAT_PRODUCT
   localparam int QUOT_W   = INT_BITS;
   localparam int REM_W    = 10;

   // Exact reciprocal for product / 1000 (product below 2^PSMALL_W)
   localparam int MQ_SHIFT = 32;
   localparam int MQ_W     = 23;
   localparam longint unsigned MQ_VAL =
      ((64'd1 << MQ_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC;
   localparam logic [MQ_W-1:0] MQ = MQ_W'(MQ_VAL);

   // Exact reciprocal for rem * 2^FRAC_BITS / 1000 (rem below 1000)
   localparam int MC_SHIFT = 20;
   localparam int MC_W     = FRAC_BITS + 11;
   localparam longint unsigned MC_VAL =
      ((64'd1 << (FRAC_BITS + MC_SHIFT)) + MS_PER_SEC - 1) / MS_PER_SEC;
   localparam logic [MC_W-1:0] MC = MC_W'(MC_VAL);

   // Duty = floor(us * 16383 / 20000), exact for 12-bit us
   localparam longint unsigned DUTY_FULL = 16383;
   localparam longint unsigned PERIOD_US = 20000;
   localparam int KD_SHIFT = 27;
   localparam int KD_W     = 27;
   localparam longint unsigned KD_VAL =
      ((DUTY_FULL << KD_SHIFT) + PERIOD_US - 1) / PERIOD_US;
   localparam logic [KD_W-1:0] KD = KD_W'(KD_VAL);

   // Configuration registers
   typedef struct packed {
      logic [US_W-1:0]    min_width;
      logic [US_W-1:0]    max_width;
      logic               invert_left;
      logic               invert_right;
      logic [SPEED_W-1:0] speed;
   } cfg_type;

   // Item leaving the step pipeline
   typedef struct packed {
      logic             active;
      logic [POS_W-1:0] step;
   } step_type;

   // Item leaving the slew stage
   typedef struct packed {
      logic [POS_W-1:0] left_pos;
      logic [POS_W-1:0] right_pos;
      logic [US_W-1:0]  left_raw;
      logic [US_W-1:0]  right_raw;
   } pos_type;

endpackage

`default_nettype wire

FILE: hdl/dssl_step_calc.sv
// Step pipeline: turns elapsed time and slew speed into a fixed-point step.
// Five registered stages; uses dssl_pkg.
`default_nettype none

module dssl_step_calc (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [dssl_pkg::SPEED_W-1:0]       speed,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire                                in_active,
   input  wire  [dssl_pkg::ELAPSED_W-1:0]     in_elapsed,
   output logic                               out_valid,
   input  wire                                out_ready,
   output dssl_pkg::step_type                 out_step
);
   import dssl_pkg::*;

   localparam int QP_W = PSMALL_W + MQ_W;
   localparam int FP_W = REM_W + MC_W;

   // Stage registers
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic                 s1_active_ff, s2_active_ff, s3_active_ff, s4_active_ff;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic                 s3_sat_ff, s4_sat_ff;
   logic [QUOT_W-1:0]    s3_quot_ff, s4_quot_ff;
   logic [PSMALL_W-1:0]  s3_psmall_ff;
   logic [REM_W-1:0]     s4_rem_ff;
   step_type             s5_step_ff;

   // Next values
   logic [PROD_W-1:0]    s2_prod_in;
   logic                 s3_sat_in;
   logic [QP_W-1:0]      quot_prod;
   logic [QUOT_W-1:0]    s3_quot_in;
   logic [PSMALL_W-1:0]  rem_wide;
   logic [REM_W-1:0]     s4_rem_in;
   logic [FP_W-1:0]      frac_prod;
   logic [FRAC_BITS-1:0] frac;
   step_type             s5_step_in;

   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

   // Ready chain, back from the output
   assign s5_rdy   = !s5_valid_ff || out_ready;
   assign s4_rdy   = !s4_valid_ff || s5_rdy;
   assign s3_rdy   = !s3_valid_ff || s4_rdy;
   assign s2_rdy   = !s2_valid_ff || s3_rdy;
   assign s1_rdy   = !s1_valid_ff || s2_rdy;
   assign in_ready = s1_rdy;

   // Stage 2: elapsed * speed
   assign s2_prod_in = PROD_W'(s1_elapsed_ff) * PROD_W'(speed);

   // Stage 3: saturation test and product / 1000
   assign s3_sat_in  = s2_prod_ff >= PROD_W'(SAT_PRODUCT);
   assign quot_prod  = QP_W'(s2_prod_ff[PSMALL_W-1:0]) * QP_W'(MQ);
   assign s3_quot_in = quot_prod[MQ_SHIFT +: QUOT_W];

   // Stage 4: remainder of product / 1000
   assign rem_wide  = s3_psmall_ff - PSMALL_W'(PSMALL_W'(s3_quot_ff) * PSMALL_W'(MS_PER_SEC));
   assign s4_rem_in = rem_wide[REM_W-1:0];

   // Stage 5: fraction bits from the remainder, then saturate
   assign frac_prod = FP_W'(s4_rem_ff) * FP_W'(MC);
   assign frac      = frac_prod[MC_SHIFT +: FRAC_BITS];

   always_comb begin
      s5_step_in.active = s4_active_ff;
      s5_step_in.step   = s4_sat_ff ? POS_FULL : {s4_quot_ff, frac};
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_valid_ff <= in_valid;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
         if (s3_rdy) s3_valid_ff <= s2_valid_ff;
         if (s4_rdy) s4_valid_ff <= s3_valid_ff;
         if (s5_rdy) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_active_ff  <= in_active;
         s1_elapsed_ff <= in_elapsed;
      end
      if (s2_rdy) begin
         s2_active_ff <= s1_active_ff;
         s2_prod_ff   <= s2_prod_in;
      end
      if (s3_rdy) begin
         s3_active_ff <= s2_active_ff;
         s3_sat_ff    <= s3_sat_in;
         s3_quot_ff   <= s3_quot_in;
         s3_psmall_ff <= s2_prod_ff[PSMALL_W-1:0];
      end
      if (s4_rdy) begin
         s4_active_ff <= s3_active_ff;
         s4_sat_ff    <= s3_sat_ff;
         s4_quot_ff   <= s3_quot_ff;
         s4_rem_ff    <= s4_rem_in;
      end
      if (s5_rdy) begin
         s5_step_ff <= s5_step_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_step  = s5_step_ff;

endmodule

`default_nettype wire

FILE: hdl/dssl_slew.sv
// Slew stage: picks and clamps the targets and moves both kept positions.
// Holds the position state; uses dssl_pkg.
`default_nettype none

module dssl_slew (
   input  wire                 clock,
   input  wire                 reset,
   input  dssl_pkg::cfg_type   cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  dssl_pkg::step_type  in_step,
   output logic                out_valid,
   input  wire                 out_ready,
   output dssl_pkg::pos_type   out_pos
);
   import dssl_pkg::*;

   // Clamp to the travel limits and move to fixed point
   function automatic logic [POS_W-1:0] clamp_fixed(input logic [US_W-1:0] us);
      logic [POS_W-1:0] fx;
      fx = POS_W'(us) << FRAC_BITS;
      if (fx < POS_LOW_FX)       return POS_LOW_FX;
      else if (fx > POS_HIGH_FX) return POS_HIGH_FX;
      else                       return fx;
   endfunction

   // Move toward the target by at most step, no overshoot
   function automatic logic [POS_W-1:0] slew(input logic [POS_W-1:0] pos,
                                             input logic [POS_W-1:0] tgt,
                                             input logic [POS_W-1:0] step);
      logic [POS_W:0]   sum;
      logic [POS_W-1:0] diff;
      logic [POS_W-1:0] res;
      sum  = {1'b0, pos} + {1'b0, step};
      diff = pos - tgt;
      if (pos < tgt)      res = (sum > {1'b0, tgt}) ? tgt : sum[POS_W-1:0];
      else if (pos > tgt) res = (diff > step) ? pos - step : tgt;
      else                res = pos;
      return res;
   endfunction

   logic [POS_W-1:0] left_pos_ff, right_pos_ff;
   logic             out_valid_ff;
   pos_type          out_pos_ff;

   logic [US_W-1:0]  left_raw, right_raw;
   logic [POS_W-1:0] left_tgt, right_tgt;
   logic [POS_W-1:0] left_start, right_start;
   logic [POS_W-1:0] left_pos_in, right_pos_in;
   logic             snap;
   logic             load;

   assign in_ready = !out_valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Target selection per channel
   assign left_raw  = (in_step.active ^ cfg.invert_left)  ? cfg.max_width : cfg.min_width;
   assign right_raw = (in_step.active ^ cfg.invert_right) ? cfg.max_width : cfg.min_width;
   assign left_tgt  = clamp_fixed(left_raw);
   assign right_tgt = clamp_fixed(right_raw);

   // An unset position snaps both channels to their targets
   assign snap        = (left_pos_ff == '0) || (right_pos_ff == '0);
   assign left_start  = snap ? left_tgt  : left_pos_ff;
   assign right_start = snap ? right_tgt : right_pos_ff;

   assign left_pos_in  = slew(left_start,  left_tgt,  in_step.step);
   assign right_pos_in = slew(right_start, right_tgt, in_step.step);

   // Position state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_pos_ff  <= '0;
         right_pos_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            left_pos_ff  <= left_pos_in;
            right_pos_ff <= right_pos_in;
         end
         if (in_ready) out_valid_ff <= in_valid;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (in_ready) begin
         out_pos_ff.left_pos  <= left_pos_in;
         out_pos_ff.right_pos <= right_pos_in;
         out_pos_ff.left_raw  <= left_raw;
         out_pos_ff.right_raw <= right_raw;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pos   = out_pos_ff;

   // Both channels are set together on the first item
   a_snap_together: assert property (@(posedge clock) disable iff (reset)
      (left_pos_ff == '0) == (right_pos_ff == '0))
      else $error("positions not set together");

   // A set position stays inside the travel limits
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (left_pos_ff != '0) |->
         (left_pos_ff >= POS_LOW_FX && left_pos_ff <= POS_HIGH_FX &&
          right_pos_ff >= POS_LOW_FX && right_pos_ff <= POS_HIGH_FX))
      else $error("position outside travel limits");

   // The item passed on carries the positions just stored
   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      (!reset && load) |=>
         (out_pos_ff.left_pos == left_pos_ff && out_pos_ff.right_pos == right_pos_ff))
      else $error("output positions differ from state");

endmodule

`default_nettype wire

FILE: hdl/dssl_result.sv
// Result stage: integer widths, duty values and the moving flag, registered
// as the result item. Uses dssl_pkg.
`default_nettype none

module dssl_result (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  dssl_pkg::pos_type            in_pos,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [dssl_pkg::US_W-1:0]    left_width_us,
   output logic [dssl_pkg::US_W-1:0]    right_width_us,
   output logic [dssl_pkg::DUTY_W-1:0]  left_duty,
   output logic [dssl_pkg::DUTY_W-1:0]  right_duty,
   output logic                         moving
);
   import dssl_pkg::*;

   localparam int DP_W = US_W + KD_W;

   // More than 1 us from the unclamped target
   function automatic logic far_from(input logic [POS_W-1:0] pos,
                                     input logic [US_W-1:0]  raw);
      logic [POS_W-1:0] t;
      logic [POS_W-1:0] d;
      t = POS_W'(raw) << FRAC_BITS;
      d = (pos > t) ? pos - t : t - pos;
      return d > POS_ONE_US;
   endfunction

   logic               rsp_valid_ff;
   logic [US_W-1:0]    left_width_ff, right_width_ff;
   logic [DUTY_W-1:0]  left_duty_ff, right_duty_ff;
   logic               moving_ff;

   logic [US_W-1:0]    left_width_in, right_width_in;
   logic [DP_W-1:0]    left_dprod, right_dprod;
   logic [DUTY_W-1:0]  left_duty_in, right_duty_in;
   logic               moving_in;

   assign in_ready = !rsp_valid_ff || rsp_ready;

   // Integer part of each position
   assign left_width_in  = in_pos.left_pos[POS_W-1:FRAC_BITS];
   assign right_width_in = in_pos.right_pos[POS_W-1:FRAC_BITS];

   // Duty by reciprocal multiply
   assign left_dprod    = DP_W'(left_width_in)  * DP_W'(KD);
   assign right_dprod   = DP_W'(right_width_in) * DP_W'(KD);
   assign left_duty_in  = left_dprod[KD_SHIFT +: DUTY_W];
   assign right_duty_in = right_dprod[KD_SHIFT +: DUTY_W];

   assign moving_in = far_from(in_pos.left_pos, in_pos.left_raw) ||
                      far_from(in_pos.right_pos, in_pos.right_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (in_ready) begin
         left_width_ff  <= left_width_in;
         right_width_ff <= right_width_in;
         left_duty_ff   <= left_duty_in;
         right_duty_ff  <= right_duty_in;
         moving_ff      <= moving_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign left_width_us  = left_width_ff;
   assign right_width_us = right_width_ff;
   assign left_duty      = left_duty_ff;
   assign right_duty     = right_duty_ff;
   assign moving         = moving_ff;

endmodule

`default_nettype wire

FILE: hdl/dual_servo_slew_limiter.sv
// Top level of the dual servo slew limiter: configuration registers, stream
// ports and the step, slew and result stages. Uses dssl_pkg and the dssl_ modules.
//
// Each request item carries an active flag and the milliseconds since the last
// update; each produces one response item with both servo pulse widths, their
// 12-bit duty values and a moving flag. The block is a seven-register pipeline
// and takes one item every cycle while the output is not stalled; a response
// passes the step stages, then the slew and result registers. The positions are
// updated in a single stage, so an item sees the positions left by the one
// before it. Configuration is written through csr_we/csr_index/csr_wdata and
// should only change while no items are in flight; unknown indexes are ignored.
`default_nettype none

module dual_servo_slew_limiter (
   input  wire                                 clock,
   input  wire                                 reset,
   // request: [0] active, [16:1] elapsed_ms
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [23:0]                         req_tdata,
   // response: [11:0] left_width_us, [23:12] right_width_us, [35:24] left_duty,
   //           [47:36] right_duty, [48] moving
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [55:0]                         rsp_tdata,
   input  wire                                 csr_we,
   input  wire  [dssl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [dssl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dssl_pkg::*;

   cfg_type            cfg_ff;

   logic               step_valid, step_ready;
   step_type           step_item;
   logic               pos_valid, pos_ready;
   pos_type            pos_item;
   logic [US_W-1:0]    left_width_us, right_width_us;
   logic [DUTY_W-1:0]  left_duty, right_duty;
   logic               moving;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width    <= MIN_WIDTH_RESET;
         cfg_ff.max_width    <= MAX_WIDTH_RESET;
         cfg_ff.invert_left  <= 1'b0;
         cfg_ff.invert_right <= 1'b0;
         cfg_ff.speed        <= SPEED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_WIDTH:    cfg_ff.min_width    <= csr_wdata[US_W-1:0];
            REG_MAX_WIDTH:    cfg_ff.max_width    <= csr_wdata[US_W-1:0];
            REG_INVERT_LEFT:  cfg_ff.invert_left  <= csr_wdata[0];
            REG_INVERT_RIGHT: cfg_ff.invert_right <= csr_wdata[0];
            REG_SPEED:        cfg_ff.speed        <= csr_wdata[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Step pipeline
   dssl_step_calc u_step (
      .clock      (clock),
      .reset      (reset),
      .speed      (cfg_ff.speed),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_active  (req_tdata[0]),
      .in_elapsed (req_tdata[ELAPSED_W:1]),
      .out_valid  (step_valid),
      .out_ready  (step_ready),
      .out_step   (step_item)
   );

   // Position update
   dssl_slew u_slew (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_step   (step_item),
      .out_valid (pos_valid),
      .out_ready (pos_ready),
      .out_pos   (pos_item)
   );

   // Result register
   dssl_result u_result (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (pos_valid),
      .in_ready       (pos_ready),
      .in_pos         (pos_item),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .left_width_us  (left_width_us),
      .right_width_us (right_width_us),
      .left_duty      (left_duty),
      .right_duty     (right_duty),
      .moving         (moving)
   );

   assign rsp_tdata = {7'b0, moving, right_duty, left_duty, right_width_us, left_width_us};

endmodule

`default_nettype wire

FILE: verif/dssl_checker.sv
`timescale 1ns / 1ps
// Checker for the dual servo slew limiter: shadows the register writes, predicts
// every response item from the accepted request items and compares them in order.
// Depends on dssl_pkg.

module dssl_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire  [23:0]                      req_tdata,    // [0] active, [16:1] elapsed_ms
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [55:0]                      rsp_tdata,    // [11:0] left us, [23:12] right us,
                                                          // [35:24] left duty,
                                                          // [47:36] right duty,
                                                          // [48] moving
   input  wire                              csr_we,
   input  wire  [dssl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [dssl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               error_count,
   output int                               outstanding
);
   import dssl_pkg::*;

   // One response item, lowest field last so it maps straight onto rsp_tdata
   typedef struct packed {
      logic              moving;
      logic [DUTY_W-1:0] right_duty;
      logic [DUTY_W-1:0] left_duty;
      logic [US_W-1:0]   right_us;
      logic [US_W-1:0]   left_us;
   } servo_reading_type;

   servo_reading_type  expected_readings[$];

   // Shadow registers and servo positions
   logic [US_W-1:0]    min_us;
   logic [US_W-1:0]    max_us;
   logic               inv_left;
   logic               inv_right;
   logic [SPEED_W-1:0] slew_speed;
   longint unsigned    left_fx;
   longint unsigned    right_fx;

   // Clamped target in fixed point
   function automatic longint unsigned travel_target(logic [US_W-1:0] us);
      longint unsigned c;
      c = us;
      if (c < POS_LOW_US) c = POS_LOW_US;
      else if (c > POS_HIGH_US) c = POS_HIGH_US;
      return c << FRAC_BITS;
   endfunction

   // Move towards the target by at most step, never past it
   function automatic longint unsigned slew_toward(longint unsigned pos,
                                                   longint unsigned tgt,
                                                   longint unsigned step);
      if (pos < tgt) begin
         pos = pos + step;
         if (pos > tgt) pos = tgt;
      end else if (pos > tgt) begin
         pos = (pos - tgt > step) ? pos - step : tgt;
      end
      return pos;
   endfunction

   // More than 1 us away from the unclamped width
   function automatic logic off_target(longint unsigned pos, logic [US_W-1:0] raw);
      longint unsigned t;
      longint unsigned d;
      t = raw;
      t = t << FRAC_BITS;
      d = (pos > t) ? pos - t : t - pos;
      return d > (64'd1 << FRAC_BITS);
   endfunction

   // Update both positions for one request item and form the reading
   function automatic servo_reading_type advance_servos(logic act,
                                                        logic [ELAPSED_W-1:0] ms);
      logic [US_W-1:0]   raw_l;
      logic [US_W-1:0]   raw_r;
      longint unsigned   tgt_l;
      longint unsigned   tgt_r;
      longint unsigned   step;
      longint unsigned   full;
      longint unsigned   wl;
      longint unsigned   wr;
      servo_reading_type r;
      raw_l = (act ^ inv_left)  ? max_us : min_us;
      raw_r = (act ^ inv_right) ? max_us : min_us;
      tgt_l = travel_target(raw_l);
      tgt_r = travel_target(raw_r);
      full  = (64'd1 << POS_W) - 1;
      // a zero position has never been set: jump straight to the targets
      if (left_fx == 0 || right_fx == 0) begin
         left_fx  = tgt_l;
         right_fx = tgt_r;
      end
      if (ms != 0) begin
         step = ms;
         step = step * slew_speed;
         step = (step << FRAC_BITS) / MS_PER_SEC;
         if (step > full) step = full;
         left_fx  = slew_toward(left_fx, tgt_l, step);
         right_fx = slew_toward(right_fx, tgt_r, step);
      end
      wl = left_fx >> FRAC_BITS;
      wr = right_fx >> FRAC_BITS;
      r.left_us    = US_W'(wl);
      r.right_us   = US_W'(wr);
      r.left_duty  = DUTY_W'((wl * DUTY_FULL) / PERIOD_US);
      r.right_duty = DUTY_W'((wr * DUTY_FULL) / PERIOD_US);
      r.moving     = off_target(left_fx, raw_l) || off_target(right_fx, raw_r);
      return r;
   endfunction

   // Watch both channels and the register port
   always @(posedge clock) begin
      servo_reading_type got;
      servo_reading_type want;
      if (reset) begin
         min_us      = MIN_WIDTH_RESET;
         max_us      = MAX_WIDTH_RESET;
         inv_left    = 1'b0;
         inv_right   = 1'b0;
         slew_speed  = SPEED_RESET;
         left_fx     = 0;
         right_fx    = 0;
         error_count = 0;
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = servo_reading_type'(rsp_tdata[48:0]);
            if (expected_readings.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response item: us %0d/%0d duty %0d/%0d moving %0b",
                           got.left_us, got.right_us, got.left_duty, got.right_duty,
                           got.moving);
            end else begin
               want = expected_readings.pop_front();
               if (got.left_us != want.left_us || got.right_us != want.right_us ||
                   got.left_duty != want.left_duty || got.right_duty != want.right_duty ||
                   got.moving != want.moving) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected us %0d/%0d duty %0d/%0d moving %0b, %s",
                              want.left_us, want.right_us, want.left_duty,
                              want.right_duty, want.moving,
                              $sformatf("got us %0d/%0d duty %0d/%0d moving %0b",
                                        got.left_us, got.right_us, got.left_duty,
                                        got.right_duty, got.moving));
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_readings.push_back(advance_servos(req_tdata[0], req_tdata[16:1]));
         // unknown indexes fall through untouched
         if (csr_we) begin
            case (csr_index)
               REG_MIN_WIDTH:    min_us     = csr_wdata[US_W-1:0];
               REG_MAX_WIDTH:    max_us     = csr_wdata[US_W-1:0];
               REG_INVERT_LEFT:  inv_left   = csr_wdata[0];
               REG_INVERT_RIGHT: inv_right  = csr_wdata[0];
               REG_SPEED:        slew_speed = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_readings.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the dual servo slew limiter testbench: clock, reset, register setup
// and request/response stimulus with random idling. Uses dssl_pkg, the block
// and dssl_checker, which does all prediction and comparison.

module testbench;
   import dssl_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [23:0]           req_tdata  = '0;   // [0] active, [16:1] elapsed_ms
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire  [55:0]           rsp_tdata;         // [11:0] left us, [23:12] right us,
                                             // [35:24] left duty, [47:36] right duty,
                                             // [48] moving
   int                    error_count;
   int                    outstanding;
   bit                    idle_on    = 1'b1;

   dual_servo_slew_limiter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dssl_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Response side back-pressure in short bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Offer one request item, with an occasional gap first; returns on a falling edge
   task automatic send_item(input logic act, input logic [ELAPSED_W-1:0] ms);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ms, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering items and wait for every response item to come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Full register set, junk in the unused upper bits, plus unknown indexes
   task automatic load_settings(input logic [US_W-1:0] min_w, input logic [US_W-1:0] max_w,
                                input logic inv_l, input logic inv_r,
                                input logic [SPEED_W-1:0] speed);
      drain();
      write_csr(REG_MIN_WIDTH, {4'($urandom), min_w});
      write_csr(REG_MAX_WIDTH, {4'($urandom), max_w});
      write_csr(REG_INVERT_LEFT, {15'($urandom), inv_l});
      write_csr(REG_INVERT_RIGHT, {15'($urandom), inv_r});
      write_csr(REG_SPEED, speed);
      for (int k = REG_SPEED + 1; k < (1 << CSR_IDX_W); k++)
         write_csr(CSR_IDX_W'(k), CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic logic [US_W-1:0] pick_width();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return US_W'($urandom_range(0, 4095));
         default: return US_W'($urandom_range(400, 2600));
      endcase
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return SPEED_W'($urandom);
         default: return SPEED_W'($urandom_range(1, 4000));
      endcase
   endfunction

   // Mostly small steps so the servos travel over many items
   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ELAPSED_W'($urandom);
         2, 3:    return ELAPSED_W'($urandom_range(1, 1000));
         default: return ELAPSED_W'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      logic act;
      act = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings; the first item finds unset positions and no elapsed time
      send_item(1'b1, 16'd0);
      send_item(1'b0, 16'd1);
      send_item(1'b0, 16'hFFFF);
      send_item(1'b1, 16'd500);
      send_item(1'b1, 16'hFFFF);
      send_item(1'b0, 16'd0);

      // Widths outside travel, full speed
      load_settings(12'd0, 12'hFFF, 1'b1, 1'b0, 16'hFFFF);
      send_item(1'b1, 16'd1);
      send_item(1'b0, 16'hFFFF);
      send_item(1'b1, 16'd3);
      send_item(1'b1, 16'd0);

      // Ends swapped, zero speed: nothing moves
      load_settings(12'hFFF, 12'd0, 1'b0, 1'b1, 16'd0);
      send_item(1'b1, 16'd100);
      send_item(1'b0, 16'hFFFF);
      send_item(1'b1, 16'd1);

      // Travel limits exactly, slowest non-zero speed
      load_settings(12'd500, 12'd2500, 1'b1, 1'b1, 16'd1);
      send_item(1'b1, 16'd1);
      send_item(1'b1, 16'd999);
      send_item(1'b1, 16'd1000);
      send_item(1'b0, 16'hFFFF);
      send_item(1'b0, 16'd1);

      // Just outside the limits; saturating step
      load_settings(12'd2501, 12'd499, 1'b0, 1'b0, 16'hFFFF);
      send_item(1'b1, 16'd64);
      send_item(1'b0, 16'd64);
      send_item(1'b1, 16'hFFFF);

      // Random phases, the last one without idling
      for (int p = 0; p < 10; p++) begin
         load_settings(pick_width(), pick_width(), 1'($urandom), 1'($urandom), pick_speed());
         idle_on = (p < 9);
         for (int n = 0; n < 110; n++) begin
            if ($urandom_range(0, 14) == 0) act = ~act;
            send_item(act, pick_elapsed());
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
